FILE: rtl/core/sbi_pkg.sv
// sbi_pkg: shared constants for the segment versus box crossing test.
// Used by sbi_edge and segment_box_intersect_top.
`default_nettype none
package sbi_pkg;

  localparam int unsigned SBI_COORD_WIDTH = 16;
  localparam int unsigned SBI_FRAC_BITS   = 4;
  localparam int unsigned SBI_SCREEN_H    = 768;
  localparam int unsigned SBI_LATENCY     = 5;

endpackage
`default_nettype wire

FILE: rtl/core/segment_box_intersect_top.sv
// segment_box_intersect_top: segment versus axis-aligned box crossing test.
// One transaction accepted every cycle; busy stays low.
// Stage 1 mirrors and builds corners; four sbi_edge lanes take stages 2 to 5.
// Results cannot be stalled; done strobes for one cycle per transaction.
// Synchronous reset clears the valid pipeline and loads screen_height with 768.0.
`default_nettype none
module segment_box_intersect_top #(
  parameter int unsigned COORD_WIDTH = sbi_pkg::SBI_COORD_WIDTH,
  parameter int unsigned FRAC_BITS   = sbi_pkg::SBI_FRAC_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [COORD_WIDTH-2:0]        cfg_data,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          func,
  input  wire logic signed [COORD_WIDTH-1:0] start_x,
  input  wire logic signed [COORD_WIDTH-1:0] start_y,
  input  wire logic signed [COORD_WIDTH-1:0] end_x,
  input  wire logic signed [COORD_WIDTH-1:0] end_y,
  input  wire logic signed [COORD_WIDTH-1:0] box_center_x,
  input  wire logic signed [COORD_WIDTH-1:0] box_center_y,
  input  wire logic [COORD_WIDTH-2:0]        box_half_width,
  input  wire logic [COORD_WIDTH-2:0]        box_half_height,
  output logic                               hit,
  output logic                               done
);

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned CW  = W + 2;
  localparam int unsigned PYW = W + 1;
  localparam int unsigned MW  = W + 1;
  localparam int unsigned LAT = sbi_pkg::SBI_LATENCY;
  localparam logic [31:0] SH_FULL = 32'(sbi_pkg::SBI_SCREEN_H * (2 ** FRAC_BITS));
  localparam logic [W-2:0] SH_RESET = SH_FULL[W-2:0];

  logic [W-2:0] screen_height;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_height <= SH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      screen_height <= cfg_data;
    end
  end

  logic accept;
  assign accept = start && !busy;

  // stage 1: mirror, corners, direction, edge multipliers
  logic signed [PYW-1:0] py_m;
  logic signed [W-1:0]   hw_s, hh_s;
  logic signed [MW-1:0]  mh, mv;
  logic signed [CW-1:0]  l_next, r_next, t_next, b_next;

  always_comb begin
    hw_s   = $signed({1'b0, box_half_width});
    hh_s   = $signed({1'b0, box_half_height});
    py_m   = func ? (PYW'($signed({2'b00, screen_height})) - PYW'(box_center_y))
                  : PYW'(box_center_y);
    l_next = CW'(box_center_x) - CW'(hw_s);
    r_next = CW'(box_center_x) + CW'(hw_s);
    t_next = CW'(py_m) + CW'(hh_s);
    b_next = CW'(py_m) - CW'(hh_s);
    mh     = $signed({1'b0, box_half_width, 1'b0});
    mv     = $signed({1'b0, box_half_height, 1'b0});
  end

  logic signed [CW-1:0]  cl, cr, ct, cb;
  logic signed [W-1:0]   ax, ay, bx, by;
  logic signed [W:0]     rx, ry;
  logic signed [MW-1:0]  m_top, m_right, m_bottom, m_left;

  always_ff @(posedge clk) begin
    cl       <= l_next;
    cr       <= r_next;
    ct       <= t_next;
    cb       <= b_next;
    ax       <= start_x;
    ay       <= start_y;
    bx       <= end_x;
    by       <= end_y;
    rx       <= (W+1)'(end_x) - (W+1)'(start_x);
    ry       <= (W+1)'(end_y) - (W+1)'(start_y);
    m_top    <= -mh;
    m_right  <= -mv;
    m_bottom <= mh;
    m_left   <= mv;
  end

  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], accept};
    end
  end

  logic [3:0] edge_hits;

  sbi_edge #(.COORD_WIDTH(COORD_WIDTH), .VERT(1'b0)) u_top (
    .clk(clk), .cx(cl), .cy(ct), .dx(cr), .dy(ct),
    .ax(ax), .ay(ay), .bx(bx), .by(by), .rx(rx), .ry(ry),
    .m(m_top), .edge_hit(edge_hits[0])
  );

  sbi_edge #(.COORD_WIDTH(COORD_WIDTH), .VERT(1'b1)) u_right (
    .clk(clk), .cx(cr), .cy(ct), .dx(cr), .dy(cb),
    .ax(ax), .ay(ay), .bx(bx), .by(by), .rx(rx), .ry(ry),
    .m(m_right), .edge_hit(edge_hits[1])
  );

  sbi_edge #(.COORD_WIDTH(COORD_WIDTH), .VERT(1'b0)) u_bottom (
    .clk(clk), .cx(cr), .cy(cb), .dx(cl), .dy(cb),
    .ax(ax), .ay(ay), .bx(bx), .by(by), .rx(rx), .ry(ry),
    .m(m_bottom), .edge_hit(edge_hits[2])
  );

  sbi_edge #(.COORD_WIDTH(COORD_WIDTH), .VERT(1'b1)) u_left (
    .clk(clk), .cx(cl), .cy(cb), .dx(cl), .dy(ct),
    .ax(ax), .ay(ay), .bx(bx), .by(by), .rx(rx), .ry(ry),
    .m(m_left), .edge_hit(edge_hits[3])
  );

  assign done = vld[LAT-1];
  assign hit  = done && (|edge_hits);

  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("done without a matching transaction");

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> screen_height == $past(cfg_data))
    else $error("screen_height not updated by write");

  a_no_done_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !done)
    else $error("done right after reset");

endmodule
`default_nettype wire

FILE: rtl/core/sbi_edge.sv
// sbi_edge: four-stage crossing test of the segment against one box edge.
// Stages: offsets, products, cross difference, sign-aware range compare.
// Depends on sbi_pkg.
`default_nettype none
module sbi_edge #(
  parameter int unsigned COORD_WIDTH = sbi_pkg::SBI_COORD_WIDTH,
  parameter bit          VERT        = 1'b0
) (
  input  wire logic                          clk,
  input  wire logic signed [COORD_WIDTH+1:0] cx,
  input  wire logic signed [COORD_WIDTH+1:0] cy,
  input  wire logic signed [COORD_WIDTH+1:0] dx,
  input  wire logic signed [COORD_WIDTH+1:0] dy,
  input  wire logic signed [COORD_WIDTH-1:0] ax,
  input  wire logic signed [COORD_WIDTH-1:0] ay,
  input  wire logic signed [COORD_WIDTH-1:0] bx,
  input  wire logic signed [COORD_WIDTH-1:0] by,
  input  wire logic signed [COORD_WIDTH:0]   rx,
  input  wire logic signed [COORD_WIDTH:0]   ry,
  input  wire logic signed [COORD_WIDTH:0]   m,
  output logic                               edge_hit
);

  localparam int unsigned CW = COORD_WIDTH + 2;
  localparam int unsigned RW = COORD_WIDTH + 1;
  localparam int unsigned MW = COORD_WIDTH + 1;
  localparam int unsigned QW = COORD_WIDTH + 3;
  localparam int unsigned PW = 2 * COORD_WIDTH + 5;

  // stage 2: offsets from segment start, corner skip
  logic signed [QW-1:0] qx, qy, qx_next, qy_next;
  logic signed [RW-1:0] rx2, ry2;
  logic signed [MW-1:0] m2;
  logic                 skip2, skip_next;

  always_comb begin
    qx_next   = QW'(cx) - QW'(ax);
    qy_next   = QW'(cy) - QW'(ay);
    skip_next = (CW'(bx) == cx && CW'(by) == cy) || (CW'(bx) == dx && CW'(by) == dy);
  end

  always_ff @(posedge clk) begin
    qx    <= qx_next;
    qy    <= qy_next;
    rx2   <= rx;
    ry2   <= ry;
    m2    <= m;
    skip2 <= skip_next;
  end

  // stage 3: products
  logic signed [RW-1:0]    rsel;
  logic signed [QW-1:0]    qsel;
  logic signed [RW+MW-1:0] den_p;
  logic signed [QW+MW-1:0] n1_p;
  logic signed [QW+RW-1:0] pa_p, pb_p;
  logic signed [PW-1:0]    den3, n13, pa3, pb3;
  logic                    skip3;

  always_comb begin
    rsel  = VERT ? rx2 : ry2;
    qsel  = VERT ? qx : qy;
    den_p = rsel * m2;
    n1_p  = qsel * m2;
    pa_p  = qx * ry2;
    pb_p  = qy * rx2;
  end

  always_ff @(posedge clk) begin
    den3  <= PW'(den_p);
    n13   <= PW'(n1_p);
    pa3   <= PW'(pa_p);
    pb3   <= PW'(pb_p);
    skip3 <= skip2;
  end

  // stage 4: second cross product
  logic signed [PW-1:0] den4, n14, n24;
  logic                 skip4;

  always_ff @(posedge clk) begin
    den4  <= den3;
    n14   <= n13;
    n24   <= pa3 - pb3;
    skip4 <= skip3;
  end

  // stage 5: both parameters within the unit range
  logic den_zero, den_pos, n1_ok, n2_ok, edge_hit_next;

  always_comb begin
    den_zero = (den4 == '0);
    den_pos  = !den4[PW-1];
    if (den_pos) begin
      n1_ok = !n14[PW-1] && (n14 <= den4);
      n2_ok = !n24[PW-1] && (n24 <= den4);
    end else begin
      n1_ok = (n14[PW-1] || n14 == '0) && (n14 >= den4);
      n2_ok = (n24[PW-1] || n24 == '0) && (n24 >= den4);
    end
    edge_hit_next = !skip4 && !den_zero && n1_ok && n2_ok;
  end

  always_ff @(posedge clk) begin
    edge_hit <= edge_hit_next;
  end

endmodule
`default_nettype wire

FILE: tb/sv/sbi_checker.sv
// sbi_checker: watches the config, command and result channels of segment_box_intersect_top,
// predicts the hit flag of every accepted transaction and compares it with the returned one.
// Depends on sbi_pkg for coordinate widths and the screen height reset value.
module sbi_checker
  import sbi_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [SBI_COORD_WIDTH-2:0]        cfg_data,
  input  logic                              start,
  input  logic                              busy,
  input  logic                              func,
  input  logic signed [SBI_COORD_WIDTH-1:0] start_x,
  input  logic signed [SBI_COORD_WIDTH-1:0] start_y,
  input  logic signed [SBI_COORD_WIDTH-1:0] end_x,
  input  logic signed [SBI_COORD_WIDTH-1:0] end_y,
  input  logic signed [SBI_COORD_WIDTH-1:0] box_center_x,
  input  logic signed [SBI_COORD_WIDTH-1:0] box_center_y,
  input  logic [SBI_COORD_WIDTH-2:0]        box_half_width,
  input  logic [SBI_COORD_WIDTH-2:0]        box_half_height,
  input  logic                              hit,
  input  logic                              done,
  output int                                fail_count,
  output int                                pending,
  output int                                hit_total
);

  localparam logic [SBI_COORD_WIDTH-2:0] HEIGHT_AT_RESET =
    (SBI_COORD_WIDTH-1)'(SBI_SCREEN_H << SBI_FRAC_BITS);

  logic [SBI_COORD_WIDTH-2:0] mirror_height;
  bit                         hit_expect_q[$];
  int                         result_index;

  initial begin
    fail_count    = 0;
    pending       = 0;
    hit_total     = 0;
    result_index  = 0;
    mirror_height = HEIGHT_AT_RESET;
  end

  task automatic report_mismatch(string msg);
    fail_count++;
    if (fail_count <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic longint cross2(longint ax, longint ay, longint bx, longint by);
    return ax * by - ay * bx;
  endfunction

  function automatic bit ratio_in_unit(longint num, longint den);
    if (den > 0) return (num >= 0) && (num <= den);
    return (num <= 0) && (num >= den);
  endfunction

  function automatic bit edge_crossed(longint ax, longint ay, longint bx, longint by,
                                      longint cx, longint cy, longint dx, longint dy);
    longint den;
    if ((bx == cx && by == cy) || (bx == dx && by == dy)) return 1'b0;
    den = cross2(bx - ax, by - ay, dx - cx, dy - cy);
    if (den == 0) return 1'b0;
    return ratio_in_unit(cross2(cx - ax, cy - ay, dx - cx, dy - cy), den) &&
           ratio_in_unit(cross2(cx - ax, cy - ay, bx - ax, by - ay), den);
  endfunction

  function automatic bit predict_hit(logic [SBI_COORD_WIDTH-2:0] height);
    longint ax, ay, bx, by, px, py, hw, hh, l, r, t, b;
    ax = longint'(start_x);
    ay = longint'(start_y);
    bx = longint'(end_x);
    by = longint'(end_y);
    px = longint'(box_center_x);
    py = longint'(box_center_y);
    hw = longint'(box_half_width);
    hh = longint'(box_half_height);
    if (func) py = longint'(height) - py;
    l = px - hw;
    r = px + hw;
    t = py + hh;
    b = py - hh;
    return edge_crossed(ax, ay, bx, by, l, t, r, t) ||
           edge_crossed(ax, ay, bx, by, r, t, r, b) ||
           edge_crossed(ax, ay, bx, by, r, b, l, b) ||
           edge_crossed(ax, ay, bx, by, l, b, l, t);
  endfunction

  always @(posedge clk) begin
    bit want;
    if (rst) begin
      mirror_height = HEIGHT_AT_RESET;
      hit_expect_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) mirror_height = cfg_data;
      if (done) begin
        result_index++;
        if (hit === 1'b1) hit_total++;
        if (hit_expect_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", result_index));
        end else begin
          want = hit_expect_q.pop_front();
          if (hit !== want)
            report_mismatch($sformatf("result %0d hit got %b want %b", result_index, hit, want));
        end
      end
      if (start && !busy) hit_expect_q.push_back(predict_hit(mirror_height));
    end
    pending <= hit_expect_q.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
// tb_top: stimulus and verdict for segment_box_intersect_top, directed cases then random
// segment/box pairs over several screen heights. Depends on sbi_pkg and sbi_checker.
module tb_top;
  import sbi_pkg::*;

  localparam int W           = SBI_COORD_WIDTH;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_JOBS = 200;

  typedef struct {
    logic                f;
    logic signed [W-1:0] sx, sy, ex, ey, cx, cy;
    logic [W-2:0]        hw, hh;
  } seg_job_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic [W-2:0]        cfg_data = '0;
  logic                start = 1'b0;
  logic                func = 1'b0;
  logic signed [W-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic signed [W-1:0] box_center_x = '0, box_center_y = '0;
  logic [W-2:0]        box_half_width = '0, box_half_height = '0;
  logic                cfg_ready, busy, hit, done;

  int fail_count, pending, hit_total;
  int cycle_count = 0;
  int directed_sent = 0;
  int random_sent = 0;
  int height_writes = 0;
  logic [W-2:0] cur_height = (W-1)'(SBI_SCREEN_H << SBI_FRAC_BITS);

  segment_box_intersect_top uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .start(start), .busy(busy), .func(func),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .box_center_x(box_center_x), .box_center_y(box_center_y),
    .box_half_width(box_half_width), .box_half_height(box_half_height),
    .hit(hit), .done(done)
  );

  sbi_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .start(start), .busy(busy), .func(func),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .box_center_x(box_center_x), .box_center_y(box_center_y),
    .box_half_width(box_half_width), .box_half_height(box_half_height),
    .hit(hit), .done(done),
    .fail_count(fail_count), .pending(pending), .hit_total(hit_total)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic seg_job_t make_job(bit f, int sx, int sy, int ex, int ey,
                                        int cx, int cy, int hw, int hh);
    seg_job_t j;
    j.f  = f;
    j.sx = W'(sx);
    j.sy = W'(sy);
    j.ex = W'(ex);
    j.ey = W'(ey);
    j.cx = W'(cx);
    j.cy = W'(cy);
    j.hw = (W-1)'(hw);
    j.hh = (W-1)'(hh);
    return j;
  endfunction

  function automatic logic signed [W-1:0] clamp_coord(longint v);
    if (v > 32767) return W'(32767);
    if (v < -32768) return W'(-32768);
    return W'(v);
  endfunction

  function automatic longint near_offset(longint h);
    return longint'($urandom_range(0, 32'(4 * h + 8))) - (2 * h + 4);
  endfunction

  function automatic seg_job_t random_job(logic [W-2:0] height);
    seg_job_t            j;
    int                  kind, span;
    logic signed [W-1:0] r16;
    longint              cx, py, hw, hh, ax, ay, bx, by;
    bit                  mir;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      j.f  = 1'($urandom);
      j.sx = W'($urandom);
      j.sy = W'($urandom);
      j.ex = W'($urandom);
      j.ey = W'($urandom);
      j.cx = W'($urandom);
      j.cy = W'($urandom);
      j.hw = (W-1)'($urandom);
      j.hh = (W-1)'($urandom);
      return j;
    end
    case ($urandom_range(0, 3))
      0: span = 16;
      1: span = 256;
      2: span = 4096;
      default: span = 32767;
    endcase
    hw = $urandom_range(0, span);
    hh = $urandom_range(0, span);
    r16 = W'($urandom);
    cx = r16 >>> $urandom_range(0, 4);
    r16 = W'($urandom);
    py = r16 >>> $urandom_range(0, 4);
    ax = cx + near_offset(hw);
    ay = py + near_offset(hh);
    bx = cx + near_offset(hw);
    by = py + near_offset(hh);
    if (kind < 30) begin
      bx = $urandom_range(0, 1) ? cx + hw : cx - hw;
      by = $urandom_range(0, 1) ? py + hh : py - hh;
    end else if (kind < 40) begin
      ay = $urandom_range(0, 1) ? py + hh : py - hh;
      by = $urandom_range(0, 1) ? ay : by;
    end else if (kind < 48) begin
      ax = $urandom_range(0, 1) ? cx + hw : cx - hw;
      bx = $urandom_range(0, 1) ? ax : bx;
    end else if (kind < 53) begin
      bx = ax;
      by = ay;
    end
    mir  = 1'($urandom_range(0, 1));
    j.f  = mir;
    j.sx = clamp_coord(ax);
    j.sy = clamp_coord(ay);
    j.ex = clamp_coord(bx);
    j.ey = clamp_coord(by);
    j.cx = clamp_coord(cx);
    j.cy = mir ? clamp_coord(longint'(height) - py) : clamp_coord(py);
    j.hw = (W-1)'(hw);
    j.hh = (W-1)'(hh);
    return j;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic send_job(seg_job_t j, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    func            <= j.f;
    start_x         <= j.sx;
    start_y         <= j.sy;
    end_x           <= j.ex;
    end_y           <= j.ey;
    box_center_x    <= j.cx;
    box_center_y    <= j.cy;
    box_half_width  <= j.hw;
    box_half_height <= j.hh;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_height(logic [W-2:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_height = value;
    height_writes++;
  endtask

  task automatic run_random(int count, bit pause_midway);
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) drain_results();
      send_job(random_job(cur_height), (i >= 40 && i < 80) ? 0 : pick_gap());
      random_sent++;
    end
  endtask

  initial begin
    seg_job_t directed[$];
    directed.push_back(make_job(0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_job(0, -1600, 0, 1600, 0, 0, 0, 800, 800));
    directed.push_back(make_job(0, -160, -160, 160, 160, 0, 0, 800, 800));
    directed.push_back(make_job(0, -1600, 800, 1600, 800, 0, 0, 800, 800));
    directed.push_back(make_job(0, 800, -1600, 800, 1600, 0, 0, 800, 800));
    directed.push_back(make_job(0, -1600, 1600, 1600, 1600, 0, 0, 800, 800));
    directed.push_back(make_job(0, -1600, -1600, 800, 800, 0, 0, 800, 800));
    directed.push_back(make_job(0, 1600, 1600, 800, -800, 0, 0, 800, 800));
    directed.push_back(make_job(0, 800, 800, -1600, -1600, 0, 0, 800, 800));
    directed.push_back(make_job(0, -1600, 0, -800, 0, 0, 0, 800, 800));
    directed.push_back(make_job(0, 0, 0, 0, 0, 0, 0, 800, 800));
    directed.push_back(make_job(0, -1600, 0, 1600, 0, 0, 0, 0, 0));
    directed.push_back(make_job(0, -1600, -100, 1600, 100, 0, 0, 0, 800));
    directed.push_back(make_job(0, 100, 100, 100, 100, 100, 100, 0, 0));
    directed.push_back(make_job(1, -100, 1500, 100, 2500, 0, 12288 - 2000, 200, 200));
    directed.push_back(make_job(1, -1600, 0, 1600, 0, 0, 12288, 800, 800));
    directed.push_back(make_job(0, -32768, -32768, 32767, 32767, 0, 0, 32767, 32767));
    directed.push_back(make_job(1, 32767, 32767, -32768, -32768, 32767, -32768, 32767, 32767));
    directed.push_back(make_job(1, -32768, 32767, 32767, -32768, -32768, 32767, 0, 32767));
    directed.push_back(make_job(0, 32767, -32768, -32768, 32767, -32768, -32768, 32767, 0));
    directed.push_back(make_job(0, 32767, 32767, 32767, 32767, 32767, 32767, 0, 0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      send_job(directed[i], pick_gap());
      directed_sent++;
    end
    run_random(RANDOM_JOBS, 1'b0);

    write_height('0);
    foreach (directed[i]) begin
      if (directed[i].f) begin
        send_job(directed[i], 0);
        directed_sent++;
      end
    end
    run_random(RANDOM_JOBS, 1'b1);

    write_height({(W-1){1'b1}});
    run_random(RANDOM_JOBS, 1'b0);

    write_height((W-1)'($urandom));
    run_random(RANDOM_JOBS, 1'b1);

    write_height((W-1)'(SBI_SCREEN_H << SBI_FRAC_BITS));
    run_random(RANDOM_JOBS, 1'b0);

    drain_results();
    repeat (SBI_LATENCY + 4) @(posedge clk);

    $display("covered %0d directed and %0d random segment/box transactions", directed_sent,
             random_sent);
    $display("over %0d screen height writes; %0d hits returned", height_writes, hit_total);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_count, pending);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
